// ----- rtl/core/agc_pkg.sv -----
// Shared types and constants for the Greek charset codec.
`default_nettype none

package agc_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_INCOMPLETE = 2'd1;
    localparam logic [1:0] ST_UNMAPPABLE = 2'd2;

    // Direction register values
    localparam logic DIR_DECODE = 1'b0;
    localparam logic DIR_ENCODE = 1'b1;

    // Default depth of the queue between front and back end
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int VALUE_W = 10;
    localparam int IN_W    = 21;

    // One queued command: up to three result values for one input item
    typedef struct packed {
        logic [2:0][VALUE_W-1:0] vals;
        logic [1:0]              last_idx;
        logic [1:0]              status;
    } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/advance_greek_codec.sv -----
// Top level of the Advance Greek charset codec.
`default_nettype none

// Converts Advance Greek bytes to code points (direction 0) or code points to
// byte sequences (direction 1). The front end takes one item per clock when
// the command queue has room; it classifies the item and queues one command
// holding all its results; a decode modifier byte that does not end the input
// queues none. The back end sends one result per clock from its output
// register while result_stall is low, so unstalled decoding sustains one item
// per cycle; encoding yields one to three results per item, set by the number
// of bytes the back end must send through the single result port. The queue
// holds QUEUE_DEPTH commands. Write direction only while the block is idle;
// a write also clears the modifier flags.
module advance_greek_codec #(
    parameter int QUEUE_DEPTH = agc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic                        cfg_wr_data,
    input  wire logic                        item_valid,
    output logic                             item_stall,
    input  wire logic [agc_pkg::IN_W-1:0]    in_value,
    input  wire logic                        end_of_input,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output logic [agc_pkg::VALUE_W-1:0]      out_value,
    output logic                             last_in_run,
    output logic [1:0]                       status
);
    import agc_pkg::*;

    logic accept;
    logic push;
    logic pop;
    logic full;
    logic empty;
    cmd_t push_cmd;
    cmd_t head_cmd;

    assign item_stall = full;
    assign accept     = item_valid && !full;

    agc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .accept       (accept),
        .in_value     (in_value),
        .end_of_input (end_of_input),
        .push         (push),
        .cmd          (push_cmd)
    );

    agc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (full),
        .empty    (empty)
    );

    agc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_cmd     (head_cmd),
        .empty        (empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_value    (out_value),
        .last_in_run  (last_in_run),
        .status       (status)
    );

endmodule

`default_nettype wire

// ----- rtl/core/agc_front.sv -----
// Front end: accepts items, tracks modifier flags, builds result commands.
`default_nettype none

module agc_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic                      cfg_wr_data,
    input  wire logic                      accept,
    input  wire logic [agc_pkg::IN_W-1:0]  in_value,
    input  wire logic                      end_of_input,
    output logic                           push,
    output agc_pkg::cmd_t                  cmd
);
    import agc_pkg::*;

    localparam logic [7:0] MOD_TONOS     = 8'h9d;
    localparam logic [7:0] MOD_DIALYTIKA = 8'h9e;
    localparam logic [7:0] MOD_CAPITAL   = 8'h9f;
    localparam logic [7:0] LETTER_FIRST  = 8'h81;
    localparam logic [7:0] LETTER_LAST   = 8'h99;
    localparam logic [9:0] SMALL_ALPHA   = 10'h3b1;
    localparam logic [9:0] CAPITAL_ALPHA = 10'h391;
    localparam logic [9:0] FINAL_SIGMA   = 10'h3c2;
    localparam logic [4:0] SLOT_IOTA     = 5'd8;
    localparam logic [4:0] SLOT_SIGMA    = 5'd17;
    localparam logic [4:0] SLOT_UPSILON  = 5'd20;

    // Tonos forms of the vowels, zero where none exists
    function automatic logic [9:0] tonos_small(input logic [4:0] slot);
        logic [9:0] r;
        unique case (slot)
            5'd0:    r = 10'h3ac;
            5'd4:    r = 10'h3ad;
            5'd6:    r = 10'h3ae;
            5'd8:    r = 10'h3af;
            5'd14:   r = 10'h3cc;
            5'd20:   r = 10'h3cd;
            5'd24:   r = 10'h3ce;
            default: r = 10'h000;
        endcase
        return r;
    endfunction

    function automatic logic [9:0] tonos_capital(input logic [4:0] slot);
        logic [9:0] r;
        unique case (slot)
            5'd0:    r = 10'h386;
            5'd4:    r = 10'h388;
            5'd6:    r = 10'h389;
            5'd8:    r = 10'h38a;
            5'd14:   r = 10'h38c;
            5'd20:   r = 10'h38e;
            5'd24:   r = 10'h38f;
            default: r = 10'h000;
        endcase
        return r;
    endfunction

    // Letter byte plus modifier flags to code point
    function automatic logic [9:0] map_letter(input logic [4:0] slot, input logic t,
                                              input logic d, input logic s);
        logic [9:0] ts;
        logic [9:0] tc;
        logic       iota;
        logic       ups;
        logic [9:0] r;
        ts   = tonos_small(slot);
        tc   = tonos_capital(slot);
        iota = (slot == SLOT_IOTA);
        ups  = (slot == SLOT_UPSILON);
        if (s) begin
            priority if (t && tc != 10'h000) r = tc;
            else if (d && iota)              r = 10'h3aa;
            else if (d && ups)               r = 10'h3ab;
            else if (slot == SLOT_SIGMA)     r = FINAL_SIGMA;
            else                             r = CAPITAL_ALPHA + {5'd0, slot};
        end
        else begin
            priority if (t && ts != 10'h000 && d && iota) r = 10'h390;
            else if (t && ts != 10'h000 && d && ups)      r = 10'h3b0;
            else if (t && ts != 10'h000)                  r = ts;
            else if (d && iota)                           r = 10'h3ca;
            else if (d && ups)                            r = 10'h3cb;
            else                                          r = SMALL_ALPHA + {5'd0, slot};
        end
        return r;
    endfunction

    // Code point to byte sequence, fewest modifiers first
    function automatic cmd_t encode_point(input logic [IN_W-1:0] x);
        cmd_t       c;
        logic [9:0] off_small;
        logic [9:0] off_cap;
        logic [9:0] let_small;
        logic [9:0] let_cap;
        logic [9:0] let_iota;
        logic [9:0] let_ups;
        off_small = x[9:0] - SMALL_ALPHA;
        off_cap   = x[9:0] - CAPITAL_ALPHA;
        let_small = {2'b00, LETTER_FIRST + {3'd0, off_small[4:0]}};
        let_cap   = {2'b00, LETTER_FIRST + {3'd0, off_cap[4:0]}};
        let_iota  = {2'b00, LETTER_FIRST + {3'd0, SLOT_IOTA}};
        let_ups   = {2'b00, LETTER_FIRST + {3'd0, SLOT_UPSILON}};
        c.vals     = '0;
        c.last_idx = 2'd0;
        c.status   = ST_OK;
        priority if (x >= IN_W'(SMALL_ALPHA) && x <= IN_W'(10'h3c9)) begin
            c.vals[0] = let_small;
        end
        else if (x >= IN_W'(CAPITAL_ALPHA) && x <= IN_W'(10'h3a9) && x != IN_W'(10'h3a2)) begin
            c.vals[0]  = {2'b00, MOD_CAPITAL};
            c.vals[1]  = let_cap;
            c.last_idx = 2'd1;
        end
        else begin
            unique case (x)
                IN_W'(10'h3ca), IN_W'(10'h3cb): begin
                    c.vals[0]  = {2'b00, MOD_DIALYTIKA};
                    c.vals[1]  = (x[0]) ? let_ups : let_iota;
                    c.last_idx = 2'd1;
                end
                IN_W'(10'h3aa), IN_W'(10'h3ab): begin
                    c.vals[0]  = {2'b00, MOD_DIALYTIKA};
                    c.vals[1]  = {2'b00, MOD_CAPITAL};
                    c.vals[2]  = (x[0]) ? let_ups : let_iota;
                    c.last_idx = 2'd2;
                end
                IN_W'(10'h3ac): begin
                    c.vals[0] = {2'b00, MOD_TONOS}; c.vals[1] = 10'h081; c.last_idx = 2'd1;
                end
                IN_W'(10'h3ad): begin
                    c.vals[0] = {2'b00, MOD_TONOS}; c.vals[1] = 10'h085; c.last_idx = 2'd1;
                end
                IN_W'(10'h3ae): begin
                    c.vals[0] = {2'b00, MOD_TONOS}; c.vals[1] = 10'h087; c.last_idx = 2'd1;
                end
                IN_W'(10'h3af): begin
                    c.vals[0] = {2'b00, MOD_TONOS}; c.vals[1] = 10'h089; c.last_idx = 2'd1;
                end
                IN_W'(10'h3cc): begin
                    c.vals[0] = {2'b00, MOD_TONOS}; c.vals[1] = 10'h08f; c.last_idx = 2'd1;
                end
                IN_W'(10'h3cd): begin
                    c.vals[0] = {2'b00, MOD_TONOS}; c.vals[1] = 10'h095; c.last_idx = 2'd1;
                end
                IN_W'(10'h3ce): begin
                    c.vals[0] = {2'b00, MOD_TONOS}; c.vals[1] = 10'h099; c.last_idx = 2'd1;
                end
                IN_W'(10'h386): begin
                    c.vals[0] = {2'b00, MOD_TONOS}; c.vals[1] = {2'b00, MOD_CAPITAL};
                    c.vals[2] = 10'h081; c.last_idx = 2'd2;
                end
                IN_W'(10'h388): begin
                    c.vals[0] = {2'b00, MOD_TONOS}; c.vals[1] = {2'b00, MOD_CAPITAL};
                    c.vals[2] = 10'h085; c.last_idx = 2'd2;
                end
                IN_W'(10'h389): begin
                    c.vals[0] = {2'b00, MOD_TONOS}; c.vals[1] = {2'b00, MOD_CAPITAL};
                    c.vals[2] = 10'h087; c.last_idx = 2'd2;
                end
                IN_W'(10'h38a): begin
                    c.vals[0] = {2'b00, MOD_TONOS}; c.vals[1] = {2'b00, MOD_CAPITAL};
                    c.vals[2] = 10'h089; c.last_idx = 2'd2;
                end
                IN_W'(10'h38c): begin
                    c.vals[0] = {2'b00, MOD_TONOS}; c.vals[1] = {2'b00, MOD_CAPITAL};
                    c.vals[2] = 10'h08f; c.last_idx = 2'd2;
                end
                IN_W'(10'h38e): begin
                    c.vals[0] = {2'b00, MOD_TONOS}; c.vals[1] = {2'b00, MOD_CAPITAL};
                    c.vals[2] = 10'h095; c.last_idx = 2'd2;
                end
                IN_W'(10'h38f): begin
                    c.vals[0] = {2'b00, MOD_TONOS}; c.vals[1] = {2'b00, MOD_CAPITAL};
                    c.vals[2] = 10'h099; c.last_idx = 2'd2;
                end
                IN_W'(10'h390), IN_W'(10'h3b0): begin
                    // small iota / upsilon with dialytika and tonos
                    c.vals[0]  = {2'b00, MOD_TONOS};
                    c.vals[1]  = {2'b00, MOD_DIALYTIKA};
                    c.vals[2]  = (x == IN_W'(10'h3b0)) ? let_ups : let_iota;
                    c.last_idx = 2'd2;
                end
                default: begin
                    if (x > IN_W'(255)) begin
                        c.status = ST_UNMAPPABLE;
                    end
                    else begin
                        c.vals[0] = x[9:0];
                    end
                end
            endcase
        end
        return c;
    endfunction

    logic       direction_reg;
    logic       accent_reg,    accent_next;
    logic       diaeresis_reg, diaeresis_next;
    logic       capital_reg,   capital_next;
    logic [7:0] byte_in;
    logic       is_mod;
    logic       is_letter;
    logic [4:0] slot;
    cmd_t       dec_cmd;
    cmd_t       enc_cmd;

    assign byte_in   = in_value[7:0];
    assign is_mod    = (byte_in == MOD_TONOS) || (byte_in == MOD_DIALYTIKA) ||
                       (byte_in == MOD_CAPITAL);
    assign is_letter = (byte_in >= LETTER_FIRST) && (byte_in <= LETTER_LAST);
    assign slot      = 5'(byte_in - LETTER_FIRST);

    // Decode path: one result per non-modifier byte, or an incomplete status at stream end
    always_comb
    begin
        dec_cmd          = '0;
        dec_cmd.last_idx = 2'd0;
        if (is_mod) begin
            dec_cmd.status = ST_INCOMPLETE;
        end
        else if (is_letter) begin
            dec_cmd.status  = ST_OK;
            dec_cmd.vals[0] = map_letter(slot, accent_reg, diaeresis_reg, capital_reg);
        end
        else begin
            dec_cmd.status  = ST_OK;
            dec_cmd.vals[0] = {2'b00, byte_in};
        end
    end

    assign enc_cmd = encode_point(in_value);

    // Command to the queue
    always_comb
    begin
        if (direction_reg == DIR_ENCODE) begin
            cmd  = enc_cmd;
            push = accept;
        end
        else begin
            cmd  = dec_cmd;
            push = accept && (!is_mod || end_of_input);
        end
    end

    // Sticky modifier flags
    always_comb
    begin
        accent_next    = accent_reg;
        diaeresis_next = diaeresis_reg;
        capital_next   = capital_reg;
        if (cfg_wr_en) begin
            accent_next    = 1'b0;
            diaeresis_next = 1'b0;
            capital_next   = 1'b0;
        end
        else if (accept && direction_reg == DIR_DECODE) begin
            if (is_mod && !end_of_input) begin
                accent_next    = accent_reg    | (byte_in == MOD_TONOS);
                diaeresis_next = diaeresis_reg | (byte_in == MOD_DIALYTIKA);
                capital_next   = capital_reg   | (byte_in == MOD_CAPITAL);
            end
            else begin
                accent_next    = 1'b0;
                diaeresis_next = 1'b0;
                capital_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            direction_reg <= DIR_DECODE;
            accent_reg    <= 1'b0;
            diaeresis_reg <= 1'b0;
            capital_reg   <= 1'b0;
        end
        else begin
            if (cfg_wr_en) begin
                direction_reg <= cfg_wr_data;
            end
            accent_reg    <= accent_next;
            diaeresis_reg <= diaeresis_next;
            capital_reg   <= capital_next;
        end
    end

    // Error results always carry a single zero value
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (push && cmd.status != ST_OK) |-> (cmd.last_idx == 2'd0 && cmd.vals[0] == 10'h000))
        else $error("error status with more than one result");

    // Flags stay clear while encoding
    a_enc_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (direction_reg == DIR_ENCODE) |-> !(accent_reg || diaeresis_reg || capital_reg))
        else $error("modifier flag set in encode mode");

endmodule

`default_nettype wire

// ----- rtl/core/agc_queue.sv -----
// Command queue between front end and back end.
`default_nettype none

module agc_queue #(
    parameter int DEPTH = agc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire agc_pkg::cmd_t push_cmd,
    input  wire logic   pop,
    output agc_pkg::cmd_t head_cmd,
    output logic        full,
    output logic        empty
);
    import agc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- rtl/core/agc_back.sv -----
// Back end: sends the values of each command one per cycle while not stalled.
`default_nettype none

module agc_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire agc_pkg::cmd_t                head_cmd,
    input  wire logic                         empty,
    output logic                              pop,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output logic [agc_pkg::VALUE_W-1:0]       out_value,
    output logic                              last_in_run,
    output logic [1:0]                        status
);
    import agc_pkg::*;

    logic               valid_reg;
    logic [1:0]         idx_reg, idx_next;
    logic [VALUE_W-1:0] value_reg;
    logic               last_reg;
    logic [1:0]         status_reg;
    logic               load;
    logic               is_last;
    logic [VALUE_W-1:0] sel_value;

    // Output register is free when empty or being taken
    assign load    = !empty && (!valid_reg || !result_stall);
    assign is_last = (idx_reg == head_cmd.last_idx);
    assign pop     = load && is_last;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sel_value = head_cmd.vals[0];
            2'd1:    sel_value = head_cmd.vals[1];
            default: sel_value = head_cmd.vals[2];
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (load) begin
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else begin
            idx_reg <= idx_next;
            if (load) begin
                valid_reg <= 1'b1;
            end
            else if (!result_stall) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load) begin
            value_reg  <= sel_value;
            last_reg   <= is_last;
            status_reg <= head_cmd.status;
        end
    end

    assign result_valid = valid_reg;
    assign out_value    = value_reg;
    assign last_in_run  = last_reg;
    assign status       = status_reg;

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (idx_reg <= head_cmd.last_idx))
        else $error("result index past end of command");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the Advance Greek charset codec.
module tb;
    import agc_pkg::*;

    // Byte codes of the charset
    localparam logic [7:0] BYTE_TONOS     = 8'h9d;
    localparam logic [7:0] BYTE_DIALYTIKA = 8'h9e;
    localparam logic [7:0] BYTE_CAPITAL   = 8'h9f;
    localparam logic [7:0] LETTER_BASE    = 8'h81;
    localparam int         LETTER_SLOTS   = 25;
    localparam int         SIGMA_SLOT     = 17;
    localparam int         PASS_MAX       = 255;

    // Code points of the letter table
    localparam logic [15:0] CP_SMALL_ALPHA   = 16'h03b1;
    localparam logic [15:0] CP_CAPITAL_ALPHA = 16'h0391;
    localparam logic [15:0] CP_FINAL_SIGMA   = 16'h03c2;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 6;

    typedef enum int {DIA_SMALL, DIA_CAPITAL, DIA_SMALL_TONOS} dia_kind_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
        logic [1:0]         st;
    } codec_result_t;

    // DUT signals
    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_wr_en    = 1'b0;
    logic               cfg_wr_data  = 1'b0;
    logic               item_valid   = 1'b0;
    logic [IN_W-1:0]    in_value     = '0;
    logic               end_of_input = 1'b0;
    logic               result_stall = 1'b0;
    logic               item_stall;
    logic               result_valid;
    logic [VALUE_W-1:0] out_value;
    logic               last_in_run;
    logic [1:0]         status;

    // Predictor state and bookkeeping
    logic            dir_setting     = DIR_DECODE;
    logic            tonos_seen      = 1'b0;
    logic            dialytika_seen  = 1'b0;
    logic            capital_seen    = 1'b0;
    codec_result_t   expected_results[$];
    int              error_count     = 0;
    int              idle_cycles     = 0;
    int              stall_left      = 0;
    bit              idle_enable     = 1'b1;

    advance_greek_codec i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .in_value     (in_value),
        .end_of_input (end_of_input),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_value    (out_value),
        .last_in_run  (last_in_run),
        .status       (status)
    );

    // Clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Tonos forms; zero where the letter has none
    function automatic logic [15:0] tonos_form(int slot, bit capital);
        case (slot)
            0:       return capital ? 16'h0386 : 16'h03ac;
            4:       return capital ? 16'h0388 : 16'h03ad;
            6:       return capital ? 16'h0389 : 16'h03ae;
            8:       return capital ? 16'h038a : 16'h03af;
            14:      return capital ? 16'h038c : 16'h03cc;
            20:      return capital ? 16'h038e : 16'h03cd;
            24:      return capital ? 16'h038f : 16'h03ce;
            default: return 16'h0000;
        endcase
    endfunction

    // Dialytika forms exist for iota and upsilon only
    function automatic logic [15:0] dialytika_form(int slot, dia_kind_t kind);
        if (slot == 8)
        begin
            case (kind)
                DIA_SMALL:   return 16'h03ca;
                DIA_CAPITAL: return 16'h03aa;
                default:     return 16'h0390;
            endcase
        end
        if (slot == 20)
        begin
            case (kind)
                DIA_SMALL:   return 16'h03cb;
                DIA_CAPITAL: return 16'h03ab;
                default:     return 16'h03b0;
            endcase
        end
        return 16'h0000;
    endfunction

    // Code point of a letter slot under the given modifier flags
    function automatic logic [15:0] letter_code(int slot, bit t, bit d, bit s);
        logic [15:0] v;
        if (s)
        begin
            // tonos wins over dialytika on a capital
            if (t && tonos_form(slot, 1'b1) != 0)
                return tonos_form(slot, 1'b1);
            if (d && dialytika_form(slot, DIA_CAPITAL) != 0)
                return dialytika_form(slot, DIA_CAPITAL);
            return (slot == SIGMA_SLOT) ? CP_FINAL_SIGMA : 16'(CP_CAPITAL_ALPHA + slot);
        end
        if (t && tonos_form(slot, 1'b0) != 0)
        begin
            v = d ? dialytika_form(slot, DIA_SMALL_TONOS) : 16'h0000;
            return (v != 0) ? v : tonos_form(slot, 1'b0);
        end
        if (d && dialytika_form(slot, DIA_SMALL) != 0)
            return dialytika_form(slot, DIA_SMALL);
        return 16'(CP_SMALL_ALPHA + slot);
    endfunction

    task automatic push_result(input logic [VALUE_W-1:0] value, input logic last,
                               input logic [1:0] st);
        codec_result_t r;
        r.value = value;
        r.last  = last;
        r.st    = st;
        expected_results.push_back(r);
    endtask

    task automatic clear_modifiers();
        tonos_seen     = 1'b0;
        dialytika_seen = 1'b0;
        capital_seen   = 1'b0;
    endtask

    // Expected results of one accepted item
    task automatic predict_conversion(input logic [IN_W-1:0] cp, input logic eoi);
        logic [7:0]  b;
        logic [7:0]  seq [3];
        logic [15:0] code;
        int          n;
        bit          found;
        b = cp[7:0];
        if (dir_setting == DIR_DECODE)
        begin
            if (b == BYTE_TONOS || b == BYTE_DIALYTIKA || b == BYTE_CAPITAL)
            begin
                if (b == BYTE_TONOS)     tonos_seen     = 1'b1;
                if (b == BYTE_DIALYTIKA) dialytika_seen = 1'b1;
                if (b == BYTE_CAPITAL)   capital_seen   = 1'b1;
                // modifier at end of stream
                if (eoi)
                begin
                    clear_modifiers();
                    push_result('0, 1'b1, ST_INCOMPLETE);
                end
            end
            else
            begin
                if (b >= LETTER_BASE && b < LETTER_BASE + LETTER_SLOTS)
                    code = letter_code(int'(b) - int'(LETTER_BASE), tonos_seen,
                                       dialytika_seen, capital_seen);
                else
                    code = {8'h00, b};
                clear_modifiers();
                push_result(code[VALUE_W-1:0], 1'b1, ST_OK);
            end
        end
        else
        begin
            // first match in binary flag order; marks in tonos, dialytika, capital order
            found = 1'b0;
            for (int combo = 0; combo < 8 && !found; combo++)
            begin
                for (int slot = 0; slot < LETTER_SLOTS && !found; slot++)
                begin
                    if (letter_code(slot, combo[2], combo[1], combo[0]) == cp)
                    begin
                        n = 0;
                        if (combo[2])
                        begin
                            seq[n] = BYTE_TONOS;
                            n++;
                        end
                        if (combo[1])
                        begin
                            seq[n] = BYTE_DIALYTIKA;
                            n++;
                        end
                        if (combo[0] && n < 2)
                        begin
                            seq[n] = BYTE_CAPITAL;
                            n++;
                        end
                        seq[n] = 8'(int'(LETTER_BASE) + slot);
                        n++;
                        for (int k = 0; k < n; k++)
                            push_result({2'b00, seq[k]}, k == n - 1, ST_OK);
                        found = 1'b1;
                    end
                end
            end
            if (!found)
            begin
                if (cp > PASS_MAX)
                    push_result('0, 1'b1, ST_UNMAPPABLE);
                else
                    push_result(cp[VALUE_W-1:0], 1'b1, ST_OK);
            end
        end
    endtask

    // Send one item; entered and left at a falling edge, valid stays high
    task automatic send_char(input logic [IN_W-1:0] cp, input logic eoi);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid   <= 1'b1;
        in_value     <= cp;
        end_of_input <= eoi;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        predict_conversion(cp, eoi);
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected result is out
    task automatic drain_results();
        item_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_direction(input logic dir);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= dir;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        dir_setting = dir;
        clear_modifiers();
    endtask

    // Plain bytes, letter table, modifier combinations, end of stream
    task automatic test_decode_directed();
        write_direction(DIR_DECODE);
        send_char(21'h000000, 1'b0);
        send_char(21'h0000ff, 1'b0);
        send_char(21'h1fff81, 1'b0);        // upper bits ignored
        send_char({13'h0, BYTE_TONOS}, 1'b0);
        send_char(21'h000081, 1'b0);
        send_char({13'h0, BYTE_CAPITAL}, 1'b0);
        send_char({13'h0, BYTE_TONOS}, 1'b0);
        send_char({13'h0, BYTE_DIALYTIKA}, 1'b0);
        send_char(21'h000089, 1'b0);        // capital iota, tonos wins
        send_char({13'h0, BYTE_TONOS}, 1'b0);
        send_char({13'h0, BYTE_DIALYTIKA}, 1'b0);
        send_char(21'h000089, 1'b1);        // small iota, both marks
        send_char({13'h0, BYTE_CAPITAL}, 1'b0);
        send_char(21'h000092, 1'b0);        // final sigma stays small
        send_char({13'h0, BYTE_DIALYTIKA}, 1'b0);
        send_char(21'h000082, 1'b0);        // mark has no form, ignored
        send_char({13'h0, BYTE_CAPITAL}, 1'b1);
    endtask

    // A register write drops pending modifiers
    task automatic test_write_clears_modifiers();
        send_char({13'h0, BYTE_TONOS}, 1'b0);
        write_direction(DIR_DECODE);
        send_char(21'h000081, 1'b0);
    endtask

    // Table lookups, pass-through and unmappable code points
    task automatic test_encode_directed();
        write_direction(DIR_ENCODE);
        send_char(21'h0003ac, 1'b0);
        send_char(21'h000390, 1'b1);        // end marker ignored
        send_char(21'h0003aa, 1'b0);
        send_char(21'h0003c2, 1'b0);
        send_char(21'h0000ff, 1'b0);
        send_char(21'h000100, 1'b0);
        send_char(21'h1fffff, 1'b0);
    endtask

    // Mostly modifier runs ending in a letter, plus noise
    task automatic test_random_decode(input int count);
        int sent;
        int pick;
        int mods;
        logic [7:0] mod_byte;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                mods = $urandom_range(0, 3);
                for (int m = 0; m < mods; m++)
                begin
                    case ($urandom_range(0, 2))
                        0:       mod_byte = BYTE_TONOS;
                        1:       mod_byte = BYTE_DIALYTIKA;
                        default: mod_byte = BYTE_CAPITAL;
                    endcase
                    send_char({13'($urandom), mod_byte}, 1'b0);
                    sent++;
                end
                send_char({13'($urandom), 8'(LETTER_BASE + $urandom_range(0, LETTER_SLOTS - 1))},
                          $urandom_range(0, 7) == 0);
            end
            else if (pick == 7)
            begin
                send_char({13'($urandom), 8'(BYTE_TONOS + $urandom_range(0, 2))}, 1'b1);
            end
            else
            begin
                send_char(21'($urandom), 1'($urandom));
            end
            sent++;
        end
    endtask

    // Mostly code points from the table, plus pass-through and unmappable
    task automatic test_random_encode(input int count);
        int pick;
        logic [IN_W-1:0] cp;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                cp = {5'h00, letter_code($urandom_range(0, LETTER_SLOTS - 1), 1'($urandom),
                                         1'($urandom), 1'($urandom))};
            else if (pick == 6)
                cp = 21'($urandom_range(0, PASS_MAX));
            else if (pick == 7)
                cp = 21'($urandom_range(PASS_MAX + 1, 1023));
            else
                cp = 21'($urandom);
            send_char(cp, 1'($urandom));
        end
    endtask

    // Alternate directions; the last phase runs without idling
    task automatic test_random_phases();
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_enable = (phase < 3);
            write_direction(DIR_DECODE);
            test_random_decode(12);
            write_direction(DIR_ENCODE);
            test_random_encode(9);
        end
    endtask

    // Result side stall in random bursts
    always @(negedge clk)
    begin
        if (stall_left == 0 && idle_enable && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 6);
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else
            result_stall <= 1'b0;
    end

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        codec_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h/%b/%0d",
                         $time, out_value, last_in_run, status);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_value !== want.value)
                begin
                    $display("%0t: out_value expected %h actual %h", $time, want.value,
                             out_value);
                    error_count++;
                end
                if (last_in_run !== want.last)
                begin
                    $display("%0t: last_in_run expected %b actual %b", $time, want.last,
                             last_in_run);
                    error_count++;
                end
                if (status !== want.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Test sequence
    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_decode_directed();
        test_write_clears_modifiers();
        test_encode_directed();
        test_random_phases();
        drain_results();
        repeat (10) @(negedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/agc_pkg.sv
rtl/core/agc_front.sv
rtl/core/agc_queue.sv
rtl/core/agc_back.sv
rtl/core/advance_greek_codec.sv
tb/tb.sv
